// ----- rtl/nqe_pkg.sv -----
// ----------------------------------------------------------------------------
// N-queens enumerator package
// Shared constants and the sequencer state type of the N-queens enumerator.
// ----------------------------------------------------------------------------
package nqe_pkg;

    localparam int MAX_QUEENS_DEFAULT = 8;
    localparam int SHOWN_COLS         = 8;
    localparam int ROW_OUT_W          = 3;
    localparam int COUNT_W            = 8;
    localparam int CFG_W              = 4;

    localparam logic [CFG_W-1:0] BOARD_SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/n_queens_solution_enumerator.sv -----
// ----------------------------------------------------------------------------
// N-queens solution enumerator
// Search time is data dependent: the sequencer steps through candidate rows,
// backtrack steps and a final decision; the single compare unit checks a
// candidate to each earlier column; the result is offered in the next cycle.
// Requests: one at a time; the next is taken after the result leaves.
// Reset: board size 8, empty board, count zero; the row stack is not cleared.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator #(
    parameter int MAX_QUEENS = nqe_pkg::MAX_QUEENS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nqe_pkg::CFG_W-1:0]      board_size,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [nqe_pkg::COUNT_W-1:0]    solution_number,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col0,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col1,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col2,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col3,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col4,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col5,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col6,
    output logic [nqe_pkg::ROW_OUT_W-1:0]  row_of_col7
);

    import nqe_pkg::*;

    // Column and row counters must hold the board size itself; stack indexes
    // only need to reach the last column.
    localparam int CW = $clog2(MAX_QUEENS + 1);
    localparam int IW = (MAX_QUEENS > 1) ? $clog2(MAX_QUEENS) : 1;
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     board_size_reg, board_size_next;
    logic [CW-1:0]        col_reg, col_next;
    logic [CW-1:0]        try_reg, try_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 exh_reg, exh_next;

    logic                 found_reg, found_next;
    logic [COUNT_W-1:0]   number_reg, number_next;
    logic [ROW_OUT_W-1:0] rows_reg [SHOWN_COLS];
    logic [ROW_OUT_W-1:0] rows_next [SHOWN_COLS];

    logic [NW-1:0]        bs_wide;
    logic [NW-1:0]        n_wide;
    logic [CW-1:0]        n_size;
    logic [CW-1:0]        col_m1;
    logic [CW-1:0]        k_plus;
    logic [CW-1:0]        rd_wide;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [IW-1:0]        wr_data;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        rd_data;
    logic [IW-1:0]        stack_rows [MAX_QUEENS];
    logic [ROW_OUT_W-1:0] shown_rows [SHOWN_COLS];

    logic                 attacked;
    logic                 give_empty;
    logic                 give_solution;
    logic                 rows_spent;
    logic                 last_check;

    // The board size in use saturates at the number of columns the stack holds.
    assign bs_wide = NW'(board_size_reg);
    assign n_wide  = (bs_wide > NW'(MAX_QUEENS)) ? NW'(MAX_QUEENS) : bs_wide;
    assign n_size  = n_wide[CW-1:0];

    assign col_m1  = col_reg - CW'(1);
    assign k_plus  = CW'(k_reg) + CW'(1);
    assign rd_wide = CW'(rd_data);

    // Decisions taken in the search and check states, one per cycle.
    assign give_empty    = exh_reg || (col_reg > n_size);
    assign give_solution = (col_reg == n_size);
    assign rows_spent    = (try_reg >= n_size);
    assign last_check    = (k_plus == col_reg);

    // The row stack is the explicit recursion: entry c holds the row of the
    // queen in column c for every column below the current one.
    nqe_row_stack #(
        .DEPTH (MAX_QUEENS),
        .IW    (IW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rows    (stack_rows)
    );

    // The shared compare unit tests the candidate row against column k_reg.
    nqe_conflict_unit #(
        .W (CW)
    ) u_conflict (
        .cand_row  (try_reg),
        .other_row (rd_wide),
        .col_dist  (col_reg - CW'(k_reg)),
        .attacked  (attacked)
    );

    // Result row fields: columns at or beyond the board read as zero, and only
    // the low three bits of a row are shown.
    genvar c;
    generate
        for (c = 0; c < SHOWN_COLS; c++)
        begin : g_shown
            if (c < MAX_QUEENS)
            begin : g_col
                logic [IW+ROW_OUT_W-1:0] row_ext;
                assign row_ext = {{ROW_OUT_W{1'b0}}, stack_rows[c]};
                assign shown_rows[c] = (CW'(c) < n_size) ? row_ext[ROW_OUT_W-1:0] : '0;
            end
            else
            begin : g_none
                assign shown_rows[c] = '0;
            end
        end
    endgenerate

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cfg_valid && in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (give_empty || give_solution)
                begin
                    state_next = ST_DONE;
                end
                else if (!rows_spent && (col_reg != '0))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (attacked || last_check)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs and the stack read address of the sequencer. In the
    // search state the stack is read one column back, for backtracking.
    always_comb
    begin
        cfg_ready = 1'b0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        rd_addr   = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_stall  = cfg_valid;
            end
            ST_SEARCH:
            begin
                rd_addr = col_m1[IW-1:0];
            end
            ST_CHECK:
            begin
                rd_addr = k_reg;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Search datapath: the state of the backtracking walk and the result.
    always_comb
    begin
        board_size_next = board_size_reg;
        col_next        = col_reg;
        try_next        = try_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        exh_next        = exh_reg;
        found_next      = found_reg;
        number_next     = number_reg;
        rows_next       = rows_reg;
        wr_en           = 1'b0;
        wr_addr         = col_reg[IW-1:0];
        wr_data         = try_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                // A configuration write also starts the enumeration over.
                if (cfg_valid)
                begin
                    board_size_next = board_size;
                    col_next        = '0;
                    try_next        = '0;
                    count_next      = '0;
                    exh_next        = 1'b0;
                end
                else if (in_valid && restart)
                begin
                    col_next   = '0;
                    try_next   = '0;
                    count_next = '0;
                    exh_next   = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (give_empty)
                begin
                    exh_next    = 1'b1;
                    found_next  = 1'b0;
                    number_next = '0;
                    for (int i = 0; i < SHOWN_COLS; i++)
                    begin
                        rows_next[i] = '0;
                    end
                end
                else if (give_solution)
                begin
                    found_next  = 1'b1;
                    number_next = count_reg;
                    rows_next   = shown_rows;
                    count_next  = count_reg + COUNT_W'(1);
                    // Resume from the last column with its next row; an empty
                    // board has only the one solution.
                    if (n_size == '0)
                    begin
                        exh_next = 1'b1;
                    end
                    else
                    begin
                        col_next = col_m1;
                        try_next = rd_wide + CW'(1);
                    end
                end
                else if (rows_spent)
                begin
                    if (col_reg == '0)
                    begin
                        exh_next = 1'b1;
                    end
                    else
                    begin
                        col_next = col_m1;
                        try_next = rd_wide + CW'(1);
                    end
                end
                else if (col_reg == '0)
                begin
                    // The first column has nothing to conflict with.
                    wr_en    = 1'b1;
                    col_next = col_reg + CW'(1);
                    try_next = '0;
                end
                else
                begin
                    k_next = '0;
                end
            end
            ST_CHECK:
            begin
                if (attacked)
                begin
                    try_next = try_reg + CW'(1);
                end
                else if (last_check)
                begin
                    wr_en    = 1'b1;
                    col_next = col_reg + CW'(1);
                    try_next = '0;
                end
                else
                begin
                    k_next = k_plus[IW-1:0];
                end
            end
            ST_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            board_size_reg <= BOARD_SIZE_RESET;
            col_reg        <= '0;
            try_reg        <= '0;
            count_reg      <= '0;
            exh_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            board_size_reg <= board_size_next;
            col_reg        <= col_next;
            try_reg        <= try_next;
            count_reg      <= count_next;
            exh_reg        <= exh_next;
        end
    end

    // Column index and result registers carry payload only.
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        found_reg  <= found_next;
        number_reg <= number_next;
        rows_reg   <= rows_next;
    end

    assign found           = found_reg;
    assign solution_number = number_reg;
    assign row_of_col0     = rows_reg[0];
    assign row_of_col1     = rows_reg[1];
    assign row_of_col2     = rows_reg[2];
    assign row_of_col3     = rows_reg[3];
    assign row_of_col4     = rows_reg[4];
    assign row_of_col5     = rows_reg[5];
    assign row_of_col6     = rows_reg[6];
    assign row_of_col7     = rows_reg[7];

endmodule

// ----- rtl/nqe_conflict_unit.sv -----
// ----------------------------------------------------------------------------
// N-queens conflict unit
// Compares a candidate row against one earlier queen for a row or diagonal hit.
// ----------------------------------------------------------------------------
module nqe_conflict_unit #(
    parameter int W = 4
) (
    input  logic [W-1:0] cand_row,
    input  logic [W-1:0] other_row,
    input  logic [W-1:0] col_dist,
    output logic         attacked
);

    logic [W-1:0] row_diff;

    always_comb
    begin
        if (other_row > cand_row)
        begin
            row_diff = other_row - cand_row;
        end
        else
        begin
            row_diff = cand_row - other_row;
        end
    end

    // Same row, or the row distance equals the column distance.
    assign attacked = (row_diff == '0) || (row_diff == col_dist);

endmodule

// ----- rtl/nqe_row_stack.sv -----
// ----------------------------------------------------------------------------
// N-queens row stack
// Holds the row placed in each column, with one write and one selected read.
// ----------------------------------------------------------------------------
module nqe_row_stack #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [IW-1:0] wr_data,
    input  logic [IW-1:0] rd_addr,
    output logic [IW-1:0] rd_data,
    output logic [IW-1:0] rows [DEPTH]
);

    logic [IW-1:0] rows_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rows_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rows_reg[rd_addr];
    assign rows    = rows_reg;

endmodule

// ----- sim/n_queens_solution_enumerator_tb.sv -----
// ----------------------------------------------------------------------------
// N-queens solution enumerator testbench
// Drives enumeration requests and board size writes into the enumerator and
// checks every returned placement against a backtracking predictor kept
// inside this bench. A short scripted opening covers the reset board, empty
// and unsolvable boards, saturated sizes and restarts. Random episodes then
// walk whole enumerations with random content and a share of cut-short,
// restart-ridden ones, under three handshake idling mixes.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_tb;

    localparam int QUEENS = nqe_pkg::MAX_QUEENS_DEFAULT;

    // One placement as the block reports it: rows[c] is the row of column c.
    typedef struct packed {
        logic                                   found;
        logic [nqe_pkg::COUNT_W-1:0]            number;
        logic [7:0][nqe_pkg::ROW_OUT_W-1:0]     rows;
    } solution_t;

    localparam solution_t NO_SOLUTION = '0;

    // One line of the scripted opening. When write_size is set, the bench
    // waits for the block to go idle and writes size before the request.
    typedef struct {
        bit                        write_size;
        logic [nqe_pkg::CFG_W-1:0] size;
        logic                      restart_flag;
        bit                        typed;
        solution_t                 want;
    } opening_line_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [nqe_pkg::CFG_W-1:0]         board_size = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic                              restart = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              found;
    logic [nqe_pkg::COUNT_W-1:0]       solution_number;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col0;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col1;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col2;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col3;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col4;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col5;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col6;
    logic [nqe_pkg::ROW_OUT_W-1:0]     row_of_col7;

    // Percent chance per cycle that the request side holds back, and that
    // the result side stalls.
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    int errors = 0;

    // Placements still owed by the block, oldest first.
    solution_t solutions_due[$];

    // Predictor state: the board size register, the explicit row stack that
    // replaces the recursion, the column being filled, the next row to try
    // there, the running solution number and the exhausted flag.
    logic [nqe_pkg::CFG_W-1:0]     size_setting = nqe_pkg::BOARD_SIZE_RESET;
    logic [2:0]                    stack_rows[QUEENS];
    int                            depth = 0;
    int                            candidate = 0;
    logic [nqe_pkg::COUNT_W-1:0]   found_count = '0;
    bit                            enumeration_over = 1'b0;

    opening_line_t opening[$];

    n_queens_solution_enumerator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .board_size      (board_size),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .solution_number (solution_number),
        .row_of_col0     (row_of_col0),
        .row_of_col1     (row_of_col1),
        .row_of_col2     (row_of_col2),
        .row_of_col3     (row_of_col3),
        .row_of_col4     (row_of_col4),
        .row_of_col5     (row_of_col5),
        .row_of_col6     (row_of_col6),
        .row_of_col7     (row_of_col7)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Empties the board and starts counting solutions from zero again.
    function void restart_search();
        depth = 0;
        candidate = 0;
        found_count = '0;
        enumeration_over = 1'b0;
    endfunction

    // True when a queen at (row, col) shares a row or a diagonal with a
    // queen already standing in an earlier column.
    function bit under_attack(input int row, input int col);
        int gap;
        for (int k = 0; k < col; k++) begin
            gap = row - int'(stack_rows[k]);
            if (gap < 0)
                gap = -gap;
            if (gap == 0 || gap == col - k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Resumes the depth-first search and returns the next placement, or an
    // all-zero result once the enumeration has run dry.
    function solution_t next_placement(input logic restart_flag);
        solution_t s;
        int n;
        s = NO_SOLUTION;
        n = (size_setting > QUEENS) ? QUEENS : int'(size_setting);
        if (restart_flag)
            restart_search();
        if (depth > n)
            enumeration_over = 1'b1;
        while (!enumeration_over) begin
            if (depth == n) begin
                s.found = 1'b1;
                s.number = found_count;
                for (int c = 0; c < n && c < 8; c++)
                    s.rows[c] = stack_rows[c];
                found_count = found_count + 1'b1;
                // An empty board has exactly one solution. Otherwise the
                // search backs up into the last column and moves its queen on.
                if (n == 0) begin
                    enumeration_over = 1'b1;
                end else begin
                    depth = n - 1;
                    candidate = int'(stack_rows[depth]) + 1;
                end
                return s;
            end
            if (candidate >= n) begin
                // Column ran out of rows: backtrack, or stop at column zero.
                if (depth == 0) begin
                    enumeration_over = 1'b1;
                end else begin
                    depth = depth - 1;
                    candidate = int'(stack_rows[depth]) + 1;
                end
            end else if (!under_attack(candidate, depth)) begin
                stack_rows[depth] = candidate[2:0];
                depth = depth + 1;
                candidate = 0;
            end else begin
                candidate = candidate + 1;
            end
        end
        return s;
    endfunction

    // Shorthand for a typed-in placement in the scripted opening.
    function solution_t placement(input int num, input int r0, input int r1,
                                  input int r2, input int r3, input int r4,
                                  input int r5, input int r6, input int r7);
        solution_t s;
        s.found = 1'b1;
        s.number = num[nqe_pkg::COUNT_W-1:0];
        s.rows = {r7[2:0], r6[2:0], r5[2:0], r4[2:0], r3[2:0], r2[2:0], r1[2:0],
                  r0[2:0]};
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request and waits for its transfer. Any hold-off comes first,
    // so in_valid is only lowered in a step that follows a transfer and is
    // never lowered and raised in the same step. On the transfer the predictor
    // advances; a typed-in value, where given, replaces its answer in the
    // queue of placements owed.
    task automatic send_request(input logic restart_flag, input bit typed,
                                input solution_t typed_value,
                                output solution_t predicted);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            restart <= 1'($urandom_range(0, 1));
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        restart <= restart_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = next_placement(restart_flag);
        solutions_due.push_back(typed ? typed_value : predicted);
    endtask

    // Stops offering requests, lets every owed placement come back, and then
    // writes the board size. The write restarts the enumeration as well.
    task automatic resize_board(input logic [nqe_pkg::CFG_W-1:0] size);
        in_valid <= 1'b0;
        while (solutions_due.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        board_size <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_setting = size;
        restart_search();
    endtask

    // One idling mix. Each episode picks a board size, then either walks the
    // enumeration to its end and a little past it, or (one time in four)
    // sends a short broken run sprinkled with restarts. Sizes from eight up
    // are picked less often since they are the slow ones.
    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input int quota);
        int sent;
        int budget;
        int tail;
        bit broken;
        logic [nqe_pkg::CFG_W-1:0] size;
        solution_t last;
        sent = 0;
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
        while (sent < quota) begin
            size = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
            resize_board(size);
            broken = ($urandom_range(0, 3) == 0);
            budget = broken ? $urandom_range(1, 40) : 200;
            tail = $urandom_range(0, 2);
            while (sent < quota && budget > 0) begin
                send_request(broken && $urandom_range(0, 7) == 0, 1'b0, NO_SOLUTION,
                             last);
                sent++;
                budget--;
                if (!last.found) begin
                    if (tail == 0)
                        break;
                    tail--;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall and in-order comparison
    // ------------------------------------------------------------------------

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Values read here are the ones before this edge, so the transfer test
    // and the stall driven for the next cycle do not race.
    always @(posedge clk) begin
        solution_t want;
        solution_t got;
        out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        if (rst_n && out_valid && !out_stall) begin
            got.found = found;
            got.number = solution_number;
            got.rows = {row_of_col7, row_of_col6, row_of_col5, row_of_col4,
                        row_of_col3, row_of_col2, row_of_col1, row_of_col0};
            if (solutions_due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing owed, expected none, got found %0d number %0d",
                         $time, got.found, got.number);
            end else begin
                want = solutions_due.pop_front();
                compare_field("found", want.found, got.found);
                compare_field("solution_number", want.number, got.number);
                for (int c = 0; c < 8; c++)
                    compare_field($sformatf("row_of_col%0d", c), want.rows[c],
                                  got.rows[c]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        solution_t first_eight;
        solution_t empty_board;
        solution_t last;
        opening_line_t line;

        for (int k = 0; k < QUEENS; k++)
            stack_rows[k] = '0;

        first_eight = placement(0, 0, 4, 7, 5, 2, 6, 1, 3);
        empty_board = placement(0, 0, 0, 0, 0, 0, 0, 0, 0);

        // Reset board is eight wide and a fresh start even without restart.
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, first_eight});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b1, 1'b1, first_eight});
        // Size zero gives one empty solution, then runs dry until restarted.
        opening.push_back('{1'b1, 4'd0, 1'b0, 1'b1, empty_board});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b1, 1'b1, empty_board});
        // A single queen, then the two unsolvable sizes.
        opening.push_back('{1'b1, 4'd1, 1'b1, 1'b1, empty_board});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd2, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd3, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b1, 1'b1, NO_SOLUTION});
        // Four queens: both solutions, exhaustion twice, then a restart.
        opening.push_back('{1'b1, 4'd4, 1'b0, 1'b1, placement(0, 1, 3, 0, 2, 0, 0, 0, 0)});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, placement(1, 2, 0, 3, 1, 0, 0, 0, 0)});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b1, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b1, 1'b1, placement(0, 1, 3, 0, 2, 0, 0, 0, 0)});
        // Sizes above the largest board saturate to eight.
        opening.push_back('{1'b1, 4'd15, 1'b0, 1'b1, first_eight});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd9, 1'b1, 1'b1, first_eight});
        // The remaining sizes, read off the predictor.
        opening.push_back('{1'b1, 4'd5, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b0, 4'd0, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd6, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd7, 1'b0, 1'b0, NO_SOLUTION});
        opening.push_back('{1'b1, 4'd8, 1'b0, 1'b1, first_eight});

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // The scripted opening runs under the first idling mix.
        sender_idle_pct = 33;
        receiver_idle_pct = 72;
        foreach (opening[i]) begin
            line = opening[i];
            if (line.write_size)
                resize_board(line.size);
            send_request(line.restart_flag, line.typed, line.want, last);
        end

        run_phase(33, 72, 210);
        run_phase(72, 33, 210);
        run_phase(0, 0, 210);

        // Let everything owed come back, then watch a while for strays.
        in_valid <= 1'b0;
        while (solutions_due.size() != 0)
            @(posedge clk);
        repeat (300)
            @(posedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial begin
        #(64'd8 * 64'd5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
